// ===== rtl/yuv2argb_pkg.sv =====
package yuv2argb_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LUMA_W  = 9;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TAB_N   = 256;

  localparam logic [KIND_W-1:0] MATRIX_BT601  = 2'd0;
  localparam logic [KIND_W-1:0] MATRIX_BT709  = 2'd1;
  localparam logic [KIND_W-1:0] MATRIX_BT2020 = 2'd2;

  localparam logic CFG_INPUT_FULL_RANGE     = 1'b0;
  localparam logic CFG_OUTPUT_LIMITED_RANGE = 1'b1;

  localparam logic [PIX_W-1:0] CHROMA_ZERO = 8'd128;

  typedef struct packed {
    logic [COEF_W-1:0] cr;
    logic [COEF_W-1:0] gu;
    logic [COEF_W-1:0] gv;
    logic [COEF_W-1:0] cb;
  } coef_t;

  typedef logic [LUMA_W-1:0] luma_tab_t [TAB_N];

  function automatic coef_t coef_sel(input logic [KIND_W-1:0] kind);
    coef_t c;
    case (kind)
      MATRIX_BT709:  c = '{cr: 17'd103206, gu: 17'd12276, gv: 17'd30679, cb: 17'd121609};
      MATRIX_BT2020: c = '{cr: 17'd96639,  gu: 17'd10784, gv: 17'd37444, cb: 17'd123299};
      default:       c = '{cr: 17'd91881,  gu: 17'd22553, gv: 17'd46802, cb: 17'd116130};
    endcase
    return c;
  endfunction

  function automatic luma_tab_t build_luma_up();
    luma_tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = LUMA_W'((i * 255) / 219);
    end
    return t;
  endfunction

  function automatic luma_tab_t build_luma_down();
    luma_tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = LUMA_W'((i * 219) / 255);
    end
    return t;
  endfunction

  localparam luma_tab_t LUMA_UP   = build_luma_up();
  localparam luma_tab_t LUMA_DOWN = build_luma_down();

  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] sum);
    logic [PIX_W-1:0] r;
    if (sum[SUM_W-1]) begin
      r = '0;
    end else if (|sum[SUM_W-2:FRAC_W+PIX_W]) begin
      r = '1;
    end else begin
      r = sum[FRAC_W+PIX_W-1:FRAC_W];
    end
    return r;
  endfunction

endpackage

// ===== rtl/yuv_to_argb_pixel_converter.sv =====
// Converts one A,Y,Cb,Cr pixel per clock, unless stalled, to A,R,G,B. Each request
// selects its matrix in s_axis_tuser (BT.601, BT.709, BT.2020; the unused code gives
// BT.601). Luma is rescaled by 255/219 or 219/255 (truncated) per the two range bits
// written on the cfg port; chroma is centered at 128 and not rescaled. Sums are
// floored and clamped to 0..255, alpha passes through. A pixel passes the input
// register and then the output register; one pixel is taken every cycle while the
// output is not stalled, set by the single input register and result register with
// stall propagating back through both. Write cfg only while the block is idle.
module yuv_to_argb_pixel_converter
  import yuv2argb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // alpha_in, luma, chroma_blue, chroma_red
  input  logic [KIND_W-1:0]   s_axis_tuser,   // matrix_kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata,   // alpha_out, red, green, blue
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data
);

  logic                input_full_range;
  logic                output_limited_range;

  logic                in_valid;
  logic [PIX_W-1:0]    in_alpha;
  logic [PIX_W-1:0]    in_luma;
  logic [PIX_W-1:0]    in_cb;
  logic [PIX_W-1:0]    in_cr;
  logic [KIND_W-1:0]   in_kind;

  logic                out_valid;
  logic [DATA_W-1:0]   out_data;

  logic                out_free;
  logic                in_free;

  coef_t                     coef;
  logic [LUMA_W-1:0]         y_scaled;
  logic signed [LUMA_W-1:0]  u;
  logic signed [LUMA_W-1:0]  v;
  logic signed [SUM_W-1:0]   yq;
  logic signed [SUM_W-1:0]   p_cr;
  logic signed [SUM_W-1:0]   p_gu;
  logic signed [SUM_W-1:0]   p_gv;
  logic signed [SUM_W-1:0]   p_cb;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_g;
  logic signed [SUM_W-1:0]   sum_b;
  logic [DATA_W-1:0]         out_data_next;

  assign out_free      = !out_valid || m_axis_tready;
  assign in_free       = !in_valid || out_free;
  assign s_axis_tready = in_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_full_range     <= 1'b0;
      output_limited_range <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_FULL_RANGE:     input_full_range     <= cfg_data;
        CFG_OUTPUT_LIMITED_RANGE: output_limited_range <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_axis_tvalid) begin
      in_alpha <= s_axis_tdata[PIX_W-1:0];
      in_luma  <= s_axis_tdata[2*PIX_W-1:PIX_W];
      in_cb    <= s_axis_tdata[3*PIX_W-1:2*PIX_W];
      in_cr    <= s_axis_tdata[4*PIX_W-1:3*PIX_W];
      in_kind  <= s_axis_tuser;
    end
  end

  always_comb begin
    coef = coef_sel(in_kind);
    case ({input_full_range, output_limited_range})
      2'b00:   y_scaled = LUMA_UP[in_luma];
      2'b11:   y_scaled = LUMA_DOWN[in_luma];
      default: y_scaled = {1'b0, in_luma};
    endcase
    u  = $signed({1'b0, in_cb}) - $signed({1'b0, CHROMA_ZERO});
    v  = $signed({1'b0, in_cr}) - $signed({1'b0, CHROMA_ZERO});
    yq = $signed({{(SUM_W-LUMA_W-FRAC_W){1'b0}}, y_scaled, {FRAC_W{1'b0}}});
    p_cr = SUM_W'($signed({1'b0, coef.cr})) * SUM_W'(v);
    p_gu = SUM_W'($signed({1'b0, coef.gu})) * SUM_W'(u);
    p_gv = SUM_W'($signed({1'b0, coef.gv})) * SUM_W'(v);
    p_cb = SUM_W'($signed({1'b0, coef.cb})) * SUM_W'(u);
    sum_r = yq + p_cr;
    sum_g = yq - p_gu - p_gv;
    sum_b = yq + p_cb;
    out_data_next = {clamp_q16(sum_b), clamp_q16(sum_g), clamp_q16(sum_r), in_alpha};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule
